// ===== hw/rtl/ufrm_pkg.sv =====
// Shared types and constants for the UART FIFO register model.
`timescale 1ns / 1ps

package ufrm_pkg;

    // Default FIFO depth in bytes
    localparam int FIFO_DEPTH_DEF = 16;

    // Fixed field widths
    localparam int BYTE_W  = 8;
    localparam int LEVEL_W = 5;
    localparam int BAUD_W  = 32;
    localparam int CFG_W   = 32;

    // Operation codes
    localparam logic [1:0] FUNC_HOST_WR   = 2'd0;
    localparam logic [1:0] FUNC_HOST_RD   = 2'd1;
    localparam logic [1:0] FUNC_LINE_PUSH = 2'd2;
    localparam logic [1:0] FUNC_LINE_POP  = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_DIS   = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;
    localparam logic [1:0] ERR_FULL  = 2'd3;

    // Register indexes
    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_BAUD   = 1'b1;

    localparam logic [BAUD_W-1:0] BAUD_RESET = 32'd115200;

    // Input word
    typedef struct packed {
        logic [1:0]        func;
        logic [BYTE_W-1:0] data_in;
    } t_in;

    // Result word
    typedef struct packed {
        logic [BYTE_W-1:0]  data_out;
        logic [1:0]         error_code;
        logic               tx_empty;
        logic               rx_available;
        logic               enabled_flag;
        logic [LEVEL_W-1:0] tx_level;
        logic [LEVEL_W-1:0] rx_level;
        logic [BYTE_W-1:0]  data_reg_value;
        logic [BAUD_W-1:0]  baud_value;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the word, read both FIFO heads
        logic execute;   // update FIFOs and load the result
    } t_cmd;

endpackage

// ===== hw/rtl/ufrm_ctrl.sv =====
// Controller state machine: sequences capture and execute for each word.
`timescale 1ns / 1ps

module ufrm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output logic           o_strobe,
    output ufrm_pkg::t_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_strobe;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_EXEC);
        end
    end

    // Commands
    assign o_cmd.capture = (r_state == ST_IDLE) && i_start;
    assign o_cmd.execute = (r_state == ST_EXEC);
    assign o_busy        = (r_state != ST_IDLE);
    assign o_strobe      = r_strobe;

endmodule

// ===== hw/rtl/ufrm_dp.sv =====
// Datapath: config registers, TX and RX FIFOs, data latch and result register.
`timescale 1ns / 1ps

module ufrm_dp #(
    parameter int FIFO_DEPTH = ufrm_pkg::FIFO_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ufrm_pkg::t_cmd             i_cmd,
    input  ufrm_pkg::t_in              i_in,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [ufrm_pkg::CFG_W-1:0] i_cfg_wdata,
    output ufrm_pkg::t_out             o_out
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int BW = ufrm_pkg::BYTE_W;
    localparam int LW = ufrm_pkg::LEVEL_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

    // Config registers
    logic                         r_enable;
    logic [ufrm_pkg::BAUD_W-1:0]  r_baud;

    // FIFO storage and pointers
    logic [BW-1:0] r_tx_mem [FIFO_DEPTH];
    logic [BW-1:0] r_rx_mem [FIFO_DEPTH];
    logic [AW-1:0] r_tx_head, r_tx_tail, r_rx_head, r_rx_tail;
    logic [CW-1:0] r_tx_count, r_rx_count;
    logic [CW-1:0] n_tx_count, n_rx_count;
    logic [BW-1:0] r_tx_rd, r_rx_rd;

    // Captured word, data latch, result
    logic [1:0]     r_func;
    logic [BW-1:0]  r_din;
    logic [BW-1:0]  r_latch;
    logic [BW-1:0]  n_latch;
    ufrm_pkg::t_out r_out;

    // Decode
    logic          tx_push, tx_pop, rx_push, rx_pop;
    logic [BW-1:0] dout;
    logic [1:0]    err;
    logic [CW+LW-1:0] tx_lvl_ext, rx_lvl_ext;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_baud   <= ufrm_pkg::BAUD_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ufrm_pkg::CFG_ENABLE) begin
                r_enable <= i_cfg_wdata[0];
            end else if (i_cfg_wdata != '0) begin
                r_baud <= i_cfg_wdata;
            end
        end
    end

    // Word capture and head reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_in.func;
            r_din   <= i_in.data_in;
            r_tx_rd <= r_tx_mem[r_tx_head];
            r_rx_rd <= r_rx_mem[r_rx_head];
        end
    end

    // Operation decode; disable check first
    always_comb begin
        tx_push = 1'b0;
        tx_pop  = 1'b0;
        rx_push = 1'b0;
        rx_pop  = 1'b0;
        dout    = '0;
        err     = ufrm_pkg::ERR_OK;
        n_latch = r_latch;
        if (r_func != ufrm_pkg::FUNC_LINE_POP && !r_enable) begin
            err = ufrm_pkg::ERR_DIS;
        end else begin
            case (r_func)
                ufrm_pkg::FUNC_HOST_WR: begin
                    if (r_tx_count == FULL_CNT) begin
                        err = ufrm_pkg::ERR_FULL;
                    end else begin
                        tx_push = 1'b1;
                        n_latch = r_din;
                    end
                end
                ufrm_pkg::FUNC_HOST_RD: begin
                    if (r_rx_count == '0) begin
                        err = ufrm_pkg::ERR_EMPTY;
                    end else begin
                        rx_pop  = 1'b1;
                        dout    = r_rx_rd;
                        n_latch = r_rx_rd;
                    end
                end
                ufrm_pkg::FUNC_LINE_PUSH: begin
                    if (r_rx_count == FULL_CNT) begin
                        err = ufrm_pkg::ERR_FULL;
                    end else begin
                        rx_push = 1'b1;
                    end
                end
                default: begin
                    if (r_tx_count == '0) begin
                        err = ufrm_pkg::ERR_EMPTY;
                    end else begin
                        tx_pop = 1'b1;
                        dout   = r_tx_rd;
                    end
                end
            endcase
        end
    end

    // Next levels
    always_comb begin
        n_tx_count = r_tx_count;
        n_rx_count = r_rx_count;
        if (tx_push) begin
            n_tx_count = r_tx_count + 1'b1;
        end else if (tx_pop) begin
            n_tx_count = r_tx_count - 1'b1;
        end
        if (rx_push) begin
            n_rx_count = r_rx_count + 1'b1;
        end else if (rx_pop) begin
            n_rx_count = r_rx_count - 1'b1;
        end
    end

    assign tx_lvl_ext = {{LW{1'b0}}, n_tx_count};
    assign rx_lvl_ext = {{LW{1'b0}}, n_rx_count};

    // FIFO writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && tx_push) begin
            r_tx_mem[r_tx_tail] <= r_din;
        end
        if (i_cmd.execute && rx_push) begin
            r_rx_mem[r_rx_tail] <= r_din;
        end
    end

    // Pointers, levels, data latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_head  <= '0;
            r_tx_tail  <= '0;
            r_rx_head  <= '0;
            r_rx_tail  <= '0;
            r_tx_count <= '0;
            r_rx_count <= '0;
            r_latch    <= '0;
        end else if (i_cmd.execute) begin
            r_tx_count <= n_tx_count;
            r_rx_count <= n_rx_count;
            r_latch    <= n_latch;
            if (tx_push) begin
                r_tx_tail <= (r_tx_tail == LAST_IDX) ? '0 : r_tx_tail + 1'b1;
            end
            if (tx_pop) begin
                r_tx_head <= (r_tx_head == LAST_IDX) ? '0 : r_tx_head + 1'b1;
            end
            if (rx_push) begin
                r_rx_tail <= (r_rx_tail == LAST_IDX) ? '0 : r_rx_tail + 1'b1;
            end
            if (rx_pop) begin
                r_rx_head <= (r_rx_head == LAST_IDX) ? '0 : r_rx_head + 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_out.data_out       <= dout;
            r_out.error_code     <= err;
            r_out.tx_empty       <= (n_tx_count == '0);
            r_out.rx_available   <= (n_rx_count != '0);
            r_out.enabled_flag   <= r_enable;
            r_out.tx_level       <= tx_lvl_ext[LW-1:0];
            r_out.rx_level       <= rx_lvl_ext[LW-1:0];
            r_out.data_reg_value <= n_latch;
            r_out.baud_value     <= r_baud;
        end
    end

    assign o_out = r_out;

endmodule

// ===== hw/rtl/uart_fifo_register_model_unit.sv =====
// Top level of the UART FIFO register model: controller plus datapath.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-----------------------------
//  command | start, busy, i_in                       | taken when start & !busy
//  result  | o_strobe, o_out                         | one cycle, no back-pressure
//  config  | i_cfg_we, i_cfg_idx, i_cfg_wdata        | written when i_cfg_we
//
// Each word has a capture step, which latches it and reads both FIFO heads from
// their registered-read memories, then an execute step, which updates the FIFOs and
// loads the result. The result shows on o_out with o_strobe high in the cycle after
// the execute step; busy is low again in that cycle, so a new word can start then.
// Synchronous active-low reset clears pointers, levels, data latch and config;
// FIFO storage needs no clearing since only written entries are read.
`timescale 1ns / 1ps

module uart_fifo_register_model_unit #(
    parameter int FIFO_DEPTH = ufrm_pkg::FIFO_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  ufrm_pkg::t_in              i_in,
    output logic                       o_strobe,
    output ufrm_pkg::t_out             o_out,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [ufrm_pkg::CFG_W-1:0] i_cfg_wdata
);

    ufrm_pkg::t_cmd cmd;

    // Sequencer
    ufrm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_cmd    (cmd)
    );

    // FIFOs and registers
    ufrm_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out       (o_out)
    );

endmodule

// ===== bench/uart_fifo_register_model_unit_tb.sv =====
// Self-checking testbench for the UART FIFO register model unit.
`timescale 1ns / 1ps

module uart_fifo_register_model_unit_tb;

    localparam int DEPTH      = ufrm_pkg::FIFO_DEPTH_DEF;
    localparam int ITEMS      = 800;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = ITEMS / PHASES;
    localparam int SETTLE_CYC = 6;

    // Traffic mixes for the random phases
    localparam int MIX_EVEN     = 0;
    localparam int MIX_TX_FILL  = 1;
    localparam int MIX_RX_FILL  = 2;
    localparam int MIX_DRAIN    = 3;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    ufrm_pkg::t_in              i_in;
    logic                       o_strobe;
    ufrm_pkg::t_out             o_out;
    logic                       i_cfg_we;
    logic                       i_cfg_idx;
    logic [ufrm_pkg::CFG_W-1:0] i_cfg_wdata;

    // Mirror of the block state
    logic [ufrm_pkg::BYTE_W-1:0] tx_bytes[$];
    logic [ufrm_pkg::BYTE_W-1:0] rx_bytes[$];
    logic [ufrm_pkg::BYTE_W-1:0] host_latch;
    logic                        uart_on;
    logic [ufrm_pkg::BAUD_W-1:0] baud_reg;

    ufrm_pkg::t_out pending_results[$];
    int             mismatches;

    uart_fifo_register_model_unit #(
        .FIFO_DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_strobe   (o_strobe),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Work out the result of one accepted word and update the mirror
    task automatic predict_uart_op(input ufrm_pkg::t_in w);
        ufrm_pkg::t_out r;
        r = '0;
        r.error_code = ufrm_pkg::ERR_OK;
        if (w.func != ufrm_pkg::FUNC_LINE_POP && !uart_on) begin
            r.error_code = ufrm_pkg::ERR_DIS;
        end else begin
            case (w.func)
                ufrm_pkg::FUNC_HOST_WR: begin
                    if (tx_bytes.size() < DEPTH) begin
                        tx_bytes.push_back(w.data_in);
                        host_latch = w.data_in;
                    end else begin
                        r.error_code = ufrm_pkg::ERR_FULL;
                    end
                end
                ufrm_pkg::FUNC_HOST_RD: begin
                    if (rx_bytes.size() > 0) begin
                        r.data_out = rx_bytes.pop_front();
                        host_latch = r.data_out;
                    end else begin
                        r.error_code = ufrm_pkg::ERR_EMPTY;
                    end
                end
                ufrm_pkg::FUNC_LINE_PUSH: begin
                    if (rx_bytes.size() < DEPTH) rx_bytes.push_back(w.data_in);
                    else r.error_code = ufrm_pkg::ERR_FULL;
                end
                default: begin
                    if (tx_bytes.size() > 0) r.data_out = tx_bytes.pop_front();
                    else r.error_code = ufrm_pkg::ERR_EMPTY;
                end
            endcase
        end
        r.tx_empty       = (tx_bytes.size() == 0);
        r.rx_available   = (rx_bytes.size() != 0);
        r.enabled_flag   = uart_on;
        r.tx_level       = ufrm_pkg::LEVEL_W'(tx_bytes.size());
        r.rx_level       = ufrm_pkg::LEVEL_W'(rx_bytes.size());
        r.data_reg_value = host_latch;
        r.baud_value     = baud_reg;
        pending_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // Result checking, then prediction of newly accepted words and register writes
    always @(posedge i_clk) begin
        ufrm_pkg::t_out want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result word with nothing pending: %h", o_out);
                end else begin
                    want = pending_results.pop_front();
                    check_field("data_out", 32'(want.data_out), 32'(o_out.data_out));
                    check_field("error_code", 32'(want.error_code),
                                32'(o_out.error_code));
                    check_field("tx_empty", 32'(want.tx_empty), 32'(o_out.tx_empty));
                    check_field("rx_available", 32'(want.rx_available),
                                32'(o_out.rx_available));
                    check_field("enabled_flag", 32'(want.enabled_flag),
                                32'(o_out.enabled_flag));
                    check_field("tx_level", 32'(want.tx_level), 32'(o_out.tx_level));
                    check_field("rx_level", 32'(want.rx_level), 32'(o_out.rx_level));
                    check_field("data_reg_value", 32'(want.data_reg_value),
                                32'(o_out.data_reg_value));
                    check_field("baud_value", want.baud_value, o_out.baud_value);
                end
            end
            if (start && !busy) predict_uart_op(i_in);
            if (i_cfg_we) begin
                if (i_cfg_idx == ufrm_pkg::CFG_ENABLE) uart_on = i_cfg_wdata[0];
                else if (i_cfg_wdata != '0) baud_reg = i_cfg_wdata;
            end
        end
    end

    // Random idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    // Present one word, hold it until taken, then idle a while
    task automatic send_word(input logic [1:0] func,
                             input logic [ufrm_pkg::BYTE_W-1:0] data);
        int gap;
        @(negedge i_clk);
        start   <= 1'b1;
        i_in    <= '{func: func, data_in: data};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        start <= 1'b0;
        gap = pick_gap();
        repeat (gap) @(negedge i_clk);
    endtask

    // Hold off until every pending word has come back and the pipe is empty
    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [ufrm_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Everything but the line-side pop is refused while disabled
    task automatic test_disabled();
        send_word(ufrm_pkg::FUNC_HOST_WR,   8'hFF);
        send_word(ufrm_pkg::FUNC_HOST_RD,   8'h00);
        send_word(ufrm_pkg::FUNC_LINE_PUSH, 8'hFF);
        send_word(ufrm_pkg::FUNC_LINE_POP,  8'h00);
    endtask

    // Enable with stray upper bits, then read and pop from empty FIFOs
    task automatic test_empty_reads();
        write_reg(ufrm_pkg::CFG_ENABLE, 32'hFFFF_FFFF);
        send_word(ufrm_pkg::FUNC_HOST_RD,  8'hFF);
        send_word(ufrm_pkg::FUNC_LINE_POP, 8'hFF);
    endtask

    // Fill TX past full, then check that a pop works and disable wins over full
    task automatic test_tx_full();
        send_word(ufrm_pkg::FUNC_HOST_WR, 8'h00);
        send_word(ufrm_pkg::FUNC_HOST_WR, 8'hFF);
        for (int k = 2; k < DEPTH; k++) send_word(ufrm_pkg::FUNC_HOST_WR, 8'(1 << (k % 8)));
        send_word(ufrm_pkg::FUNC_HOST_WR, 8'hA5);
        wait_drained();
        write_reg(ufrm_pkg::CFG_ENABLE, 32'hFFFF_FFFE);
        send_word(ufrm_pkg::FUNC_HOST_WR,  8'h5A);
        send_word(ufrm_pkg::FUNC_LINE_POP, 8'h00);
        send_word(ufrm_pkg::FUNC_HOST_WR,  8'h5A);
    endtask

    // Baud register: zero is ignored, extremes are kept
    task automatic test_baud_config();
        wait_drained();
        write_reg(ufrm_pkg::CFG_BAUD, 32'h0000_0000);
        send_word(ufrm_pkg::FUNC_LINE_POP, 8'h00);
        wait_drained();
        write_reg(ufrm_pkg::CFG_BAUD, 32'h0000_0001);
        write_reg(ufrm_pkg::CFG_ENABLE, 32'h0000_0001);
        send_word(ufrm_pkg::FUNC_LINE_POP, 8'h00);
        wait_drained();
        write_reg(ufrm_pkg::CFG_BAUD, 32'hFFFF_FFFF);
        send_word(ufrm_pkg::FUNC_LINE_PUSH, 8'h3C);
    endtask

    function automatic logic [1:0] pick_func(input int mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_TX_FILL: return (roll < 65) ? ufrm_pkg::FUNC_HOST_WR :
                                2'($urandom_range(ufrm_pkg::FUNC_HOST_RD,
                                                  ufrm_pkg::FUNC_LINE_POP));
            MIX_RX_FILL: return (roll < 65) ? ufrm_pkg::FUNC_LINE_PUSH :
                                (roll < 80) ? ufrm_pkg::FUNC_HOST_RD :
                                (roll < 90) ? ufrm_pkg::FUNC_HOST_WR :
                                              ufrm_pkg::FUNC_LINE_POP;
            MIX_DRAIN:   return (roll < 40) ? ufrm_pkg::FUNC_HOST_RD :
                                (roll < 80) ? ufrm_pkg::FUNC_LINE_POP :
                                (roll < 90) ? ufrm_pkg::FUNC_HOST_WR :
                                              ufrm_pkg::FUNC_LINE_PUSH;
            default:     return 2'($urandom_range(0, 3));
        endcase
    endfunction

    // Phases of random traffic with a register change between them
    task automatic test_random_traffic();
        logic [ufrm_pkg::CFG_W-1:0] baud;
        logic                       on;
        int                         mix;
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            on = (p != 3);
            write_reg(ufrm_pkg::CFG_ENABLE, {31'($urandom()), on});
            case (p % 4)
                0: baud = 32'hFFFF_FFFF;
                1: baud = 32'h0000_0001;
                2: baud = 32'h0000_0000;
                default: baud = $urandom();
            endcase
            write_reg(ufrm_pkg::CFG_BAUD, baud);
            for (int k = 0; k < PHASE_LEN; k++) begin
                // Switch traffic mix every so often so the FIFOs swing full and empty
                if (k % 20 == 0) mix = $urandom_range(MIX_EVEN, MIX_DRAIN);
                send_word(pick_func(mix), 8'($urandom_range(0, 255)));
                if (k == PHASE_LEN / 2 && p == 1) wait_drained();
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_in        = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = ufrm_pkg::CFG_ENABLE;
        i_cfg_wdata = '0;
        host_latch  = '0;
        uart_on     = 1'b0;
        baud_reg    = ufrm_pkg::BAUD_RESET;
        mismatches  = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_disabled();
        test_empty_reads();
        test_tx_full();
        test_baud_config();
        test_random_traffic();

        wait_drained();
        if (mismatches == 0) begin
            $display("uart_fifo_register_model_unit_tb passed");
        end else begin
            $display("uart_fifo_register_model_unit_tb failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(2_000_000);
        $display("uart_fifo_register_model_unit_tb failed");
        $finish;
    end

endmodule
